@@ rtl/bps_pkg.sv @@
// Shared types and constants of the page statistics and reference scan block.
`default_nettype none

package bps_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_PAGE = 1'd1;

  localparam int unsigned PAGE_SIZE_W     = 13;
  localparam int unsigned PAGE_SIZE_RESET = 4096;

  localparam int unsigned CNT_W  = 32;
  localparam int unsigned SUM_W  = 48;
  localparam int unsigned OFF_W  = 18;
  localparam int unsigned DSZ_W  = 18;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned HDR_W  = 96;
  localparam int unsigned CELL_W = 16;
  localparam int unsigned IDX_W  = 12;

  localparam logic [LEN_W-1:0] HDR_LEN  = 4'd12;
  localparam logic [LEN_W-1:0] PTR_LEN  = 4'd2;
  localparam logic [LEN_W-1:0] WORD_LEN = 4'd4;

  localparam logic [OFF_W-1:0] CELL_ARRAY_OFF = 18'd12;
  localparam logic [DSZ_W-1:0] HDR_RESERVED   = 18'd5;

  localparam logic [7:0] TYPE_LEAF     = 8'd10;
  localparam logic [7:0] TYPE_INTERIOR = 8'd2;

  localparam logic [1:0] KIND_RIGHT   = 2'd0;
  localparam logic [1:0] KIND_CELL    = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic [1:0] CLASS_OTHER    = 2'd0;
  localparam logic [1:0] CLASS_LEAF     = 2'd1;
  localparam logic [1:0] CLASS_INTERIOR = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              report_kind;
    logic [CNT_W-1:0]        page_number;
    logic [IDX_W-1:0]        cell_index;
    logic [1:0]              page_class;
    logic [CNT_W-1:0]        leaf_pages_total;
    logic [SUM_W-1:0]        leaf_cells_total;
    logic signed [SUM_W-1:0] leaf_data_total;
    logic [CNT_W-1:0]        parent_pages_total;
    logic [SUM_W-1:0]        parent_cells_total;
    logic signed [SUM_W-1:0] parent_data_total;
    logic                    reports_dropped;
    logic                    last_of_page;
  } report_t;

  typedef struct packed {
    logic             go;
    logic [OFF_W-1:0] base;
    logic [LEN_W-1:0] len;
  } fetch_req_t;

  typedef struct packed {
    logic             done;
    logic [HDR_W-1:0] word;
  } fetch_rsp_t;

endpackage

`default_nettype wire

@@ rtl/bps_stream_if.sv @@
// Valid/ready stream channel carrying one payload per transfer.
`default_nettype none

interface bps_stream_if #(
  parameter type payload_t = logic [7:0]
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/bps_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module bps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/bps_fetch.sv @@
// Byte fetch unit: reads a run of page bytes big-endian, zero past the page end.
`default_nettype none

module bps_fetch #(
  parameter int unsigned MAX_PAGE_BYTES = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  bps_pkg::fetch_req_t                   req,
  input  logic [$clog2(MAX_PAGE_BYTES+1)-1:0]   size,
  output logic [$clog2(MAX_PAGE_BYTES)-1:0]     raddr,
  input  logic [7:0]                            rdata,
  output bps_pkg::fetch_rsp_t                   rsp
);

  localparam int unsigned AW = $clog2(MAX_PAGE_BYTES);

  logic                          busy;
  logic                          done;
  logic [bps_pkg::LEN_W-1:0]     cnt;
  logic [bps_pkg::LEN_W-1:0]     len;
  logic [bps_pkg::OFF_W-1:0]     base;
  logic [bps_pkg::OFF_W-1:0]     off;
  logic                          ok_q;
  logic [bps_pkg::HDR_W-1:0]     word;

  assign off   = base + bps_pkg::OFF_W'(cnt);
  assign raddr = off[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !req.go && busy && (cnt == len);
      if (req.go) begin
        busy <= 1'b1;
        cnt  <= '0;
        base <= req.base;
        len  <= req.len;
      end else if (busy) begin
        if (cnt != '0) begin
          word <= {word[bps_pkg::HDR_W-9:0], (ok_q ? rdata : 8'd0)};
        end
        ok_q <= (cnt < len) && (off < bps_pkg::OFF_W'(size));
        cnt  <= cnt + 1'b1;
        if (cnt == len) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.word = word;

`ifndef SYNTHESIS
  a_go_when_free: assert property (@(posedge clk) disable iff (rst) req.go |-> !busy)
    else $error("fetch started while busy");
`endif

endmodule

`default_nettype wire

@@ rtl/bps_ctrl.sv @@
// Page sequencer: header decode, running totals, pointer scan and report register.
`default_nettype none

module bps_ctrl #(
  parameter int unsigned MAX_PAGE_BYTES = 4096,
  parameter int unsigned MAX_REPORTS    = 63
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                page_done,
  input  logic [$clog2(MAX_PAGE_BYTES+1)-1:0] size,
  input  logic [bps_pkg::CNT_W-1:0]           target_page,
  output logic                                busy,
  output bps_pkg::fetch_req_t                 req,
  input  bps_pkg::fetch_rsp_t                 rsp,
  bps_stream_if.source                        report_out
);

  localparam int unsigned RW = $clog2(MAX_REPORTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_HDR, S_ACC, S_RPTR, S_CELL, S_PTR, S_CHILD, S_EMIT, S_SUM
  } state_t;

  state_t                         state;
  logic [bps_pkg::CNT_W-1:0]      page_cnt;
  logic [bps_pkg::CNT_W-1:0]      leaf_pages;
  logic [bps_pkg::SUM_W-1:0]      leaf_cells;
  logic [bps_pkg::SUM_W-1:0]      leaf_data;
  logic [bps_pkg::CNT_W-1:0]      par_pages;
  logic [bps_pkg::SUM_W-1:0]      par_cells;
  logic [bps_pkg::SUM_W-1:0]      par_data;
  logic [1:0]                     cls;
  logic [bps_pkg::CELL_W-1:0]     cells;
  logic [bps_pkg::DSZ_W-1:0]      dsz;
  logic [bps_pkg::CNT_W-1:0]      rptr;
  logic [bps_pkg::CELL_W-1:0]     idx;
  logic [bps_pkg::OFF_W-1:0]      ptr_off;
  logic [RW-1:0]                  nrep;
  logic                           dropped;
  logic                           out_valid;
  bps_pkg::report_t               out_data;
  bps_pkg::report_t               rep;
  logic                           out_free;
  logic [bps_pkg::SUM_W-1:0]      dsz_ext;
  logic [bps_pkg::IDX_W-1:0]      idx_sat;
  logic [7:0]                     hdr_type;
  logic                           ptr_in_page;
  logic                           load;
  logic                           go_next;

  assign out_free = !out_valid || report_out.ready;
  assign dsz_ext  = {{(bps_pkg::SUM_W - bps_pkg::DSZ_W){dsz[bps_pkg::DSZ_W-1]}}, dsz};
  assign idx_sat  = (idx[bps_pkg::CELL_W-1:bps_pkg::IDX_W] != '0) ? '1
                                                                  : idx[bps_pkg::IDX_W-1:0];
  assign hdr_type = rsp.word[95:88];
  assign busy     = (state != S_IDLE);

  assign ptr_in_page = bps_pkg::OFF_W'(rsp.word[15:0]) < bps_pkg::OFF_W'(size);
  assign load        = out_free && ((state == S_RPTR && rptr == target_page) ||
                                    state == S_EMIT || state == S_SUM);
  assign go_next     = (state == S_IDLE && page_done) ||
                       (state == S_CELL && idx < cells) ||
                       (state == S_PTR && rsp.done && ptr_in_page);

  assign report_out.valid   = out_valid;
  assign report_out.payload = out_data;

  always_comb begin
    rep                    = '0;
    rep.page_number        = page_cnt;
    rep.page_class         = cls;
    rep.leaf_pages_total   = leaf_pages;
    rep.leaf_cells_total   = leaf_cells;
    rep.leaf_data_total    = leaf_data;
    rep.parent_pages_total = par_pages;
    rep.parent_cells_total = par_cells;
    rep.parent_data_total  = par_data;
    if (state == S_RPTR) begin
      rep.report_kind = bps_pkg::KIND_RIGHT;
    end else if (state == S_EMIT) begin
      rep.report_kind = bps_pkg::KIND_CELL;
      rep.cell_index  = idx_sat;
    end else begin
      rep.report_kind     = bps_pkg::KIND_SUMMARY;
      rep.reports_dropped = dropped;
      rep.last_of_page    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      req.go     <= 1'b0;
      page_cnt   <= '0;
      leaf_pages <= '0;
      leaf_cells <= '0;
      leaf_data  <= '0;
      par_pages  <= '0;
      par_cells  <= '0;
      par_data   <= '0;
      nrep       <= '0;
      dropped    <= 1'b0;
    end else begin
      req.go <= go_next;
      if (load) begin
        out_valid <= 1'b1;
        out_data  <= rep;
      end else if (report_out.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (page_done) begin
            page_cnt <= page_cnt + 1'b1;
            req.base <= '0;
            req.len  <= bps_pkg::HDR_LEN;
            state    <= S_HDR;
          end
        end
        S_HDR: begin
          if (rsp.done) begin
            if (hdr_type == bps_pkg::TYPE_LEAF) begin
              cls <= bps_pkg::CLASS_LEAF;
            end else if (hdr_type == bps_pkg::TYPE_INTERIOR) begin
              cls <= bps_pkg::CLASS_INTERIOR;
            end else begin
              cls <= bps_pkg::CLASS_OTHER;
            end
            cells <= rsp.word[71:56];
            dsz   <= bps_pkg::DSZ_W'(size) - bps_pkg::HDR_RESERVED
                     - bps_pkg::DSZ_W'(rsp.word[55:40]);
            rptr  <= rsp.word[31:0];
            state <= S_ACC;
          end
        end
        S_ACC: begin
          nrep    <= '0;
          dropped <= 1'b0;
          idx     <= '0;
          ptr_off <= bps_pkg::CELL_ARRAY_OFF;
          if (cls == bps_pkg::CLASS_LEAF) begin
            leaf_pages <= leaf_pages + 1'b1;
            leaf_cells <= leaf_cells + bps_pkg::SUM_W'(cells);
            leaf_data  <= leaf_data + dsz_ext;
            state      <= S_SUM;
          end else if (cls == bps_pkg::CLASS_INTERIOR) begin
            par_pages <= par_pages + 1'b1;
            par_cells <= par_cells + bps_pkg::SUM_W'(cells);
            par_data  <= par_data + dsz_ext;
            state     <= S_RPTR;
          end else begin
            state <= S_SUM;
          end
        end
        S_RPTR: begin
          if (rptr != target_page) begin
            state <= S_CELL;
          end else if (out_free) begin
            nrep  <= RW'(1);
            state <= S_CELL;
          end
        end
        S_CELL: begin
          if (idx < cells) begin
            req.base <= ptr_off;
            req.len  <= bps_pkg::PTR_LEN;
            state    <= S_PTR;
          end else begin
            state <= S_SUM;
          end
        end
        S_PTR: begin
          if (rsp.done) begin
            if (ptr_in_page) begin
              req.base <= bps_pkg::OFF_W'(rsp.word[15:0]);
              req.len  <= bps_pkg::WORD_LEN;
              state    <= S_CHILD;
            end else begin
              idx     <= idx + 1'b1;
              ptr_off <= ptr_off + 2'd2;
              state   <= S_CELL;
            end
          end
        end
        S_CHILD: begin
          if (rsp.done) begin
            if (rsp.word[31:0] == target_page && nrep < RW'(MAX_REPORTS)) begin
              state <= S_EMIT;
            end else begin
              if (rsp.word[31:0] == target_page) begin
                dropped <= 1'b1;
              end
              idx     <= idx + 1'b1;
              ptr_off <= ptr_off + 2'd2;
              state   <= S_CELL;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            nrep    <= nrep + 1'b1;
            idx     <= idx + 1'b1;
            ptr_off <= ptr_off + 2'd2;
            state   <= S_CELL;
          end
        end
        S_SUM: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_close_when_idle: assert property (@(posedge clk) disable iff (rst)
    page_done |-> state == S_IDLE)
    else $error("page closed while previous page still in progress");
  a_report_bound: assert property (@(posedge clk) disable iff (rst)
    nrep <= RW'(MAX_REPORTS))
    else $error("match report count above limit");
  a_fetch_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !req.go)
    else $error("fetch issued while idle");
`endif

endmodule

`default_nettype wire

@@ rtl/btree_page_stats_ref_scan_top.sv @@
// Top level of the page statistics and reference scan block.
//
//   channel     dir  payload              transfer
//   byte_in     in   in_item_t (8 bits)   valid & ready
//   report_out  out  report_t             valid & ready
//   cfg_*       in   index, 32-bit data   cfg_we
//
// Page bytes are taken one per cycle and written to the page RAM; the closing byte
// starts the scan and byte_in is held off until the summary is loaded.
// The closing byte starts the header fetch and the totals update; interior pages then
// check the right pointer, each cell pointer, and the word of each in-page pointer.
// A waiting match report stalls the scan; a waiting summary does not stop intake.
// Reset is synchronous; page RAM contents are not cleared.
`default_nettype none

module btree_page_stats_ref_scan_top #(
  parameter int unsigned MAX_PAGE_BYTES = 4096,
  parameter int unsigned MAX_REPORTS    = 63
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bps_pkg::CFG_DATA_W-1:0]     cfg_data,
  bps_stream_if.sink                         byte_in,
  bps_stream_if.source                       report_out
);

  localparam int unsigned AW = $clog2(MAX_PAGE_BYTES);
  localparam int unsigned PW = $clog2(MAX_PAGE_BYTES + 1);
  localparam int unsigned SIZE_RST = (bps_pkg::PAGE_SIZE_RESET > MAX_PAGE_BYTES)
                                     ? MAX_PAGE_BYTES : bps_pkg::PAGE_SIZE_RESET;

  logic [PW-1:0]                    size;
  logic [bps_pkg::CNT_W-1:0]        target_page;
  logic [bps_pkg::PAGE_SIZE_W-1:0]  size_wr;
  logic [PW-1:0]                    size_eff;
  logic [AW-1:0]                    pos;
  logic [PW-1:0]                    pos_inc;
  logic                             accept;
  logic                             page_done;
  logic                             busy;
  logic [AW-1:0]                    raddr;
  logic [7:0]                       rdata;
  bps_pkg::fetch_req_t              req;
  bps_pkg::fetch_rsp_t              rsp;

  assign size_wr  = cfg_data[bps_pkg::PAGE_SIZE_W-1:0];
  assign size_eff = (size_wr == '0) ? PW'(1)
                  : (32'(size_wr) > 32'(MAX_PAGE_BYTES)) ? PW'(MAX_PAGE_BYTES)
                  : PW'(size_wr);

  always_ff @(posedge clk) begin
    if (rst) begin
      size        <= PW'(SIZE_RST);
      target_page <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bps_pkg::REG_PAGE_SIZE:   size        <= size_eff;
        bps_pkg::REG_TARGET_PAGE: target_page <= cfg_data;
        default: ;
      endcase
    end
  end

  assign byte_in.ready = !busy;
  assign accept        = byte_in.valid && byte_in.ready;
  assign pos_inc       = PW'(pos) + 1'b1;
  assign page_done     = accept && (pos_inc >= size);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      pos <= page_done ? '0 : pos_inc[AW-1:0];
    end
  end

  bps_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAGE_BYTES)
  ) u_page_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (pos),
    .wdata (byte_in.payload.data_byte),
    .raddr (raddr),
    .rdata (rdata)
  );

  bps_fetch #(
    .MAX_PAGE_BYTES (MAX_PAGE_BYTES)
  ) u_fetch (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .size  (size),
    .raddr (raddr),
    .rdata (rdata),
    .rsp   (rsp)
  );

  bps_ctrl #(
    .MAX_PAGE_BYTES (MAX_PAGE_BYTES),
    .MAX_REPORTS    (MAX_REPORTS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .page_done   (page_done),
    .size        (size),
    .target_page (target_page),
    .busy        (busy),
    .req         (req),
    .rsp         (rsp),
    .report_out  (report_out)
  );

`ifndef SYNTHESIS
  a_hold_after_close: assert property (@(posedge clk) disable iff (rst)
    page_done |=> !byte_in.ready)
    else $error("byte intake open after page close");
`endif

endmodule

`default_nettype wire

@@ verif/page_scan_checker.sv @@
// Checker for the page statistics block: predicts reports from observed transfers and compares.
`timescale 1ns / 100ps

module page_scan_checker #(
  parameter int unsigned MAX_PAGE_BYTES = 4096,
  parameter int unsigned MAX_REPORTS    = 63
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bps_pkg::CFG_DATA_W-1:0] cfg_data,
  bps_stream_if                          byte_ch,
  bps_stream_if                          report_ch,
  output int unsigned                    fail_count,
  output int unsigned                    owed
);

  localparam int unsigned      OFF_CELLS    = 3;
  localparam int unsigned      OFF_CONTENT  = 5;
  localparam int unsigned      OFF_RIGHT    = 8;
  localparam int unsigned      CELL_IDX_MAX = (1 << bps_pkg::IDX_W) - 1;
  localparam int unsigned      SHOWN_FAILS  = 10;

  logic [7:0]                      page_mem [MAX_PAGE_BYTES];
  logic [bps_pkg::PAGE_SIZE_W-1:0] size_reg;
  logic [31:0]                     target_reg;
  int unsigned                     fill;
  logic [bps_pkg::CNT_W-1:0]       page_no;
  logic [bps_pkg::CNT_W-1:0]       leaf_pages;
  logic [bps_pkg::SUM_W-1:0]       leaf_cells;
  logic [bps_pkg::SUM_W-1:0]       leaf_data;
  logic [bps_pkg::CNT_W-1:0]       parent_pages;
  logic [bps_pkg::SUM_W-1:0]       parent_cells;
  logic [bps_pkg::SUM_W-1:0]       parent_data;
  bps_pkg::report_t                owed_reports [$];

  function automatic int unsigned live_size();
    if (size_reg == '0) return 1;
    if (size_reg > MAX_PAGE_BYTES) return MAX_PAGE_BYTES;
    return int'(size_reg);
  endfunction

  function automatic logic [7:0] peek8(input int unsigned off, input int unsigned sz);
    if (off >= sz || off >= MAX_PAGE_BYTES) return 8'h00;
    return page_mem[off];
  endfunction

  function automatic logic [15:0] peek16(input int unsigned off, input int unsigned sz);
    return {peek8(off, sz), peek8(off + 1, sz)};
  endfunction

  function automatic logic [31:0] peek32(input int unsigned off, input int unsigned sz);
    return {peek16(off, sz), peek16(off + 2, sz)};
  endfunction

  function automatic bps_pkg::report_t compose_report(input logic [1:0] kind,
                                                      input logic [bps_pkg::IDX_W-1:0] slot,
                                                      input logic [1:0] cls,
                                                      input logic dropped,
                                                      input logic last);
    bps_pkg::report_t r;
    r.report_kind        = kind;
    r.page_number        = page_no;
    r.cell_index         = slot;
    r.page_class         = cls;
    r.leaf_pages_total   = leaf_pages;
    r.leaf_cells_total   = leaf_cells;
    r.leaf_data_total    = leaf_data;
    r.parent_pages_total = parent_pages;
    r.parent_cells_total = parent_cells;
    r.parent_data_total  = parent_data;
    r.reports_dropped    = dropped;
    r.last_of_page       = last;
    return r;
  endfunction

  function automatic string show(input bps_pkg::report_t r);
    return $sformatf({"kind=%0d page=%0d cell=%0d class=%0d leaf=%0d/%0d/%0d ",
                      "parent=%0d/%0d/%0d dropped=%0b last=%0b"},
                     r.report_kind, r.page_number, r.cell_index, r.page_class,
                     r.leaf_pages_total, r.leaf_cells_total, r.leaf_data_total,
                     r.parent_pages_total, r.parent_cells_total, r.parent_data_total,
                     r.reports_dropped, r.last_of_page);
  endfunction

  task automatic note_failure(input string what);
    if (fail_count < SHOWN_FAILS) $display("%s", what);
    fail_count++;
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    int unsigned               sz;
    int unsigned               ncells;
    int unsigned               i;
    int unsigned               p;
    int unsigned               hits;
    logic [7:0]                type_byte;
    logic [bps_pkg::SUM_W-1:0] room;
    logic [1:0]                cls;
    logic                      dropped;
    sz = live_size();
    if (fill < MAX_PAGE_BYTES) page_mem[fill] = b;
    fill++;
    if (fill < sz) return;
    fill = 0;
    page_no++;
    type_byte = peek8(0, sz);
    ncells = peek16(OFF_CELLS, sz);
    room = bps_pkg::SUM_W'(sz) - bps_pkg::SUM_W'(bps_pkg::HDR_RESERVED)
           - bps_pkg::SUM_W'(peek16(OFF_CONTENT, sz));
    cls = bps_pkg::CLASS_OTHER;
    dropped = 1'b0;
    hits = 0;
    if (type_byte == bps_pkg::TYPE_LEAF) begin
      cls = bps_pkg::CLASS_LEAF;
      leaf_pages++;
      leaf_cells += bps_pkg::SUM_W'(ncells);
      leaf_data += room;
    end else if (type_byte == bps_pkg::TYPE_INTERIOR) begin
      cls = bps_pkg::CLASS_INTERIOR;
      parent_pages++;
      parent_cells += bps_pkg::SUM_W'(ncells);
      parent_data += room;
    end
    if (cls == bps_pkg::CLASS_INTERIOR) begin
      if (peek32(OFF_RIGHT, sz) == target_reg) begin
        owed_reports.push_back(compose_report(bps_pkg::KIND_RIGHT, '0, cls, 1'b0, 1'b0));
        hits++;
      end
      for (i = 0; i < ncells; i++) begin
        p = peek16(bps_pkg::CELL_ARRAY_OFF + 2 * i, sz);
        if (p < sz && peek32(p, sz) == target_reg) begin
          if (hits < MAX_REPORTS) begin
            owed_reports.push_back(compose_report(bps_pkg::KIND_CELL,
                bps_pkg::IDX_W'(i > CELL_IDX_MAX ? CELL_IDX_MAX : i), cls, 1'b0, 1'b0));
            hits++;
          end else begin
            dropped = 1'b1;
          end
        end
      end
    end
    owed_reports.push_back(compose_report(bps_pkg::KIND_SUMMARY, '0, cls, dropped, 1'b1));
  endtask

  task automatic match_report(input bps_pkg::report_t got);
    bps_pkg::report_t want;
    if (owed_reports.size() == 0) begin
      note_failure({"unexpected report: ", show(got)});
      return;
    end
    want = owed_reports.pop_front();
    if (got.report_kind        !== want.report_kind        ||
        got.page_number        !== want.page_number        ||
        got.cell_index         !== want.cell_index         ||
        got.page_class         !== want.page_class         ||
        got.leaf_pages_total   !== want.leaf_pages_total   ||
        got.leaf_cells_total   !== want.leaf_cells_total   ||
        got.leaf_data_total    !== want.leaf_data_total    ||
        got.parent_pages_total !== want.parent_pages_total ||
        got.parent_cells_total !== want.parent_cells_total ||
        got.parent_data_total  !== want.parent_data_total  ||
        got.reports_dropped    !== want.reports_dropped    ||
        got.last_of_page       !== want.last_of_page)
      note_failure($sformatf("report mismatch\n  expected %s\n  actual   %s",
                             show(want), show(got)));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      size_reg     = bps_pkg::PAGE_SIZE_W'(bps_pkg::PAGE_SIZE_RESET);
      target_reg   = '0;
      fill         = 0;
      page_no      = '0;
      leaf_pages   = '0;
      leaf_cells   = '0;
      leaf_data    = '0;
      parent_pages = '0;
      parent_cells = '0;
      parent_data  = '0;
      fail_count   = 0;
      owed_reports.delete();
    end else begin
      if (report_ch.valid && report_ch.ready) match_report(report_ch.payload);
      if (byte_ch.valid && byte_ch.ready) absorb_byte(byte_ch.payload.data_byte);
      if (cfg_we) begin
        if (cfg_index == bps_pkg::REG_PAGE_SIZE) begin
          size_reg = cfg_data[bps_pkg::PAGE_SIZE_W-1:0];
        end else if (cfg_index == bps_pkg::REG_TARGET_PAGE) begin
          target_reg = cfg_data;
        end
      end
    end
    owed = owed_reports.size();
  end

endmodule

@@ verif/btree_page_stats_ref_scan_top_tb.sv @@
// Testbench top: page stimulus and configuration for the page statistics block, and the verdict.
`timescale 1ns / 100ps

module btree_page_stats_ref_scan_top_tb;

  localparam int unsigned MAX_PAGE_BYTES = 4096;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned CYCLE_LIMIT    = 400_000;
  localparam int unsigned RANDOM_PHASES  = 2;

  typedef enum int unsigned {RX_OPEN, RX_COIN, RX_CHOKE, RX_LIGHT} rx_mode_t;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_we;
  logic [bps_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bps_pkg::CFG_DATA_W-1:0] cfg_data;
  int unsigned                    fail_count;
  int unsigned                    owed;
  int unsigned                    cycles = 0;

  logic [7:0]            page_img [MAX_PAGE_BYTES];
  int unsigned           cur_size = bps_pkg::PAGE_SIZE_RESET;
  logic [31:0]           cur_target = '0;
  int unsigned           burst_left = 0;
  bit                    gappy = 1'b1;

  bps_stream_if #(.payload_t(bps_pkg::in_item_t)) byte_ch ();
  bps_stream_if #(.payload_t(bps_pkg::report_t))  report_ch ();

  btree_page_stats_ref_scan_top u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .byte_in    (byte_ch),
    .report_out (report_ch)
  );

  page_scan_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .byte_ch    (byte_ch),
    .report_ch  (report_ch),
    .fail_count (fail_count),
    .owed       (owed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : report_sink
    int unsigned span;
    rx_mode_t    mode;
    report_ch.ready <= 1'b0;
    span = 0;
    mode = RX_OPEN;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        span = $urandom_range(5, 60);
      end
      span--;
      case (mode)
        RX_OPEN:  report_ch.ready <= 1'b1;
        RX_COIN:  report_ch.ready <= ($urandom_range(0, 1) == 1);
        RX_CHOKE: report_ch.ready <= ($urandom_range(0, 7) == 0);
        default:  report_ch.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = gappy ? $urandom_range(1, 10) : 0;
      if (gap != 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.payload <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic send_page(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) send_byte(page_img[i]);
  endtask

  // drop valid, wait for every owed report, then let the block go quiet
  task automatic settle();
    byte_ch.valid <= 1'b0;
    burst_left = 0;
    while (owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(input logic [bps_pkg::CFG_IDX_W-1:0] idx,
                         input logic [bps_pkg::CFG_DATA_W-1:0] val);
    logic [bps_pkg::PAGE_SIZE_W-1:0] sz;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    sz = val[bps_pkg::PAGE_SIZE_W-1:0];
    if (idx == bps_pkg::REG_PAGE_SIZE)
      cur_size = (sz == '0) ? 1 : ((sz > MAX_PAGE_BYTES) ? MAX_PAGE_BYTES : int'(sz));
    else
      cur_target = val;
  endtask

  task automatic put16(input int unsigned off, input logic [15:0] v);
    if (off < MAX_PAGE_BYTES) page_img[off] = v[15:8];
    if (off + 1 < MAX_PAGE_BYTES) page_img[off + 1] = v[7:0];
  endtask

  task automatic put32(input int unsigned off, input logic [31:0] v);
    put16(off, v[31:16]);
    put16(off + 2, v[15:0]);
  endtask

  // random bytes; a stray interior type keeps its cell count low
  task automatic fill_noise(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) page_img[i] = 8'($urandom);
    if (page_img[0] == bps_pkg::TYPE_INTERIOR) page_img[3] = 8'h00;
  endtask

  task automatic build_leaf(input int unsigned n);
    fill_noise(n);
    page_img[0] = bps_pkg::TYPE_LEAF;
    put16(3, 16'($urandom_range(0, 65535)));
    put16(5, 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, n)));
  endtask

  task automatic build_interior(input int unsigned n, input int unsigned ncells, input bit flood);
    int unsigned lo;
    int unsigned spot;
    int unsigned i;
    int unsigned p;
    bit          have_spot;
    fill_noise(n);
    page_img[0] = bps_pkg::TYPE_INTERIOR;
    put16(3, 16'(ncells));
    put16(5, 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, n)));
    if ($urandom_range(0, 1) == 1) put32(8, cur_target);
    lo = 12 + 2 * ncells;
    have_spot = (lo + 4 <= n);
    spot = have_spot ? $urandom_range(lo, n - 4) : 0;
    if (have_spot) put32(spot, cur_target);
    for (i = 0; i < ncells && 12 + 2 * i < n; i++) begin
      if (!have_spot) p = $urandom_range(0, n + 16);
      else if (flood) p = spot;
      else begin
        case ($urandom_range(0, 7))
          0, 1, 2: p = spot;
          3:       p = n + $urandom_range(0, 64);
          4:       p = (n > 3) ? n - $urandom_range(1, 3) : 0;
          default: p = $urandom_range(0, n - 1);
        endcase
      end
      put16(12 + 2 * i, 16'(p));
    end
  endtask

  task automatic random_page(input int unsigned n);
    int unsigned cap;
    int unsigned pick;
    cap = (n > 12) ? (n - 12) / 2 : 0;
    pick = $urandom_range(0, 19);
    if (pick < 9) build_interior(n, $urandom_range(0, (cap < 120) ? cap : 120), 1'b0);
    else if (pick < 14) build_leaf(n);
    else if (pick < 17) fill_noise(n);
    else if (pick < 19) build_interior(n, cap + $urandom_range(1, 40), 1'b0);
    else build_interior(n, (cap < 200) ? cap : 200, 1'b1);
    send_page(n);
  endtask

  initial begin : stimulus
    int unsigned i;
    int unsigned ph;
    int unsigned k;
    int unsigned pages;
    int unsigned sz;
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= bps_pkg::REG_PAGE_SIZE;
    cfg_data        <= '0;
    byte_ch.valid   <= 1'b0;
    byte_ch.payload <= '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    settle();

    // values after reset, then the page size shrunk below the bytes already taken
    build_interior(24, 4, 1'b0);
    for (i = 0; i < 20; i++) send_byte(page_img[i]);
    settle();
    set_reg(bps_pkg::REG_PAGE_SIZE, 32'd12);
    send_byte(page_img[20]);
    settle();
    set_reg(bps_pkg::REG_PAGE_SIZE, 32'd24);
    build_interior(cur_size, 4, 1'b0);
    send_page(cur_size);
    settle();

    // zero page size acts as one byte per page
    set_reg(bps_pkg::REG_PAGE_SIZE, 32'd0);
    send_byte(bps_pkg::TYPE_LEAF);
    send_byte(bps_pkg::TYPE_INTERIOR);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(bps_pkg::TYPE_INTERIOR);
    settle();

    set_reg(bps_pkg::REG_PAGE_SIZE, 32'd13);
    set_reg(bps_pkg::REG_TARGET_PAGE, $urandom);
    build_interior(cur_size, 1, 1'b0);
    send_page(cur_size);
    build_interior(cur_size, 3, 1'b0);
    send_page(cur_size);
    settle();

    // oversized values saturate, so a few bytes never close a page
    build_leaf(5);
    set_reg(bps_pkg::REG_PAGE_SIZE, 32'd8191);
    for (i = 0; i < 3; i++) send_byte(page_img[i]);
    settle();
    set_reg(bps_pkg::REG_PAGE_SIZE, 32'd4097);
    send_byte(page_img[3]);
    settle();
    set_reg(bps_pkg::REG_PAGE_SIZE, 32'd4);
    send_byte(page_img[4]);
    settle();

    set_reg(bps_pkg::REG_PAGE_SIZE, 32'd16);
    set_reg(bps_pkg::REG_TARGET_PAGE, 32'hFFFF_FFFF);
    build_leaf(cur_size);
    put16(3, 16'hFFFF);
    put16(5, 16'hFFFF);
    send_page(cur_size);
    build_leaf(cur_size);
    put16(3, 16'h0000);
    put16(5, 16'h0000);
    send_page(cur_size);
    build_interior(cur_size, 1, 1'b0);
    put32(8, 32'hFFFF_FFFF);
    send_page(cur_size);
    settle();

    // cell count runs past the pointer array: those pointers read as zero
    set_reg(bps_pkg::REG_TARGET_PAGE, 32'h025A_C301);
    fill_noise(cur_size);
    page_img[0] = bps_pkg::TYPE_INTERIOR;
    page_img[1] = 8'h5A;
    page_img[2] = 8'hC3;
    put16(3, 16'd300);
    put16(12, 16'h0000);
    put16(14, 16'h0000);
    send_page(cur_size);

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      case ($urandom_range(0, 3))
        0, 1:    sz = $urandom_range(12, 16);
        2:       sz = $urandom_range(4, 11);
        default: sz = $urandom_range(1, 3);
      endcase
      set_reg(bps_pkg::REG_PAGE_SIZE, 32'(sz));
      set_reg(bps_pkg::REG_TARGET_PAGE,
              ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 64)) : $urandom);
      gappy = ($urandom_range(0, 3) != 0);
      pages = $urandom_range(1, 2);
      for (k = 0; k < pages; k++) random_page(cur_size);
    end
    settle();

    if (fail_count == 0 && owed == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bps_pkg.sv
rtl/bps_stream_if.sv
rtl/bps_ram.sv
rtl/bps_fetch.sv
rtl/bps_ctrl.sv
rtl/btree_page_stats_ref_scan_top.sv
verif/page_scan_checker.sv
verif/btree_page_stats_ref_scan_top_tb.sv
